// ===== sv/mrse_pkg.sv =====
`timescale 1ns / 1ps

package mrse_pkg;

    // Default sizes
    localparam int STORE_BYTES_DEF   = 1024;
    localparam int REQUEST_BYTES_DEF = 32;

    // Read size limits (registers)
    localparam logic [7:0] MAX_READ_REGS = 8'd30;
    localparam logic [7:0] READ_CAP      = 8'd30;

    // CRC-16 constants
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Function and exception codes
    localparam logic [7:0] FUNC_READ     = 8'h03;
    localparam logic [7:0] FUNC_WRITE    = 8'h10;
    localparam logic [7:0] EXC_READ      = 8'h83;
    localparam logic [7:0] EXC_WRITE     = 8'h90;
    localparam logic [7:0] EXC_ILL_VALUE = 8'h03;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_READ_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_WRITE_LIMIT   = 2'd2;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [4:0] read_limit;
        logic [6:0] write_limit;
    } cfg_t;

    // Request header fields, zero where not received
    typedef struct packed {
        logic [7:0]  func;
        logic [15:0] addr;
        logic [7:0]  cnt;
        logic [7:0]  nbytes;
    } hdr_t;

    typedef enum logic [1:0] {
        RSP_EXC,
        RSP_READ,
        RSP_WRITE
    } rsp_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_DECIDE,
        ST_HDR,
        ST_RD_REQ,
        ST_RD_DATA,
        ST_CRC_LO,
        ST_CRC_HI,
        ST_WR_REQ,
        ST_WR_DATA
    } state_t;

    // Feed one byte into the Modbus CRC-16
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== sv/modbus_rtu_slave_register_engine.sv =====
`timescale 1ns / 1ps
// After the last request word, ST_MOD and ST_DECIDE precede the first response word,
// then one response word per cycle for header and CRC unless tx_stall holds it; each
// stored word is read in ST_RD_REQ and sent in ST_RD_DATA. One request word per cycle
// while idle; a function 16 frame writes its data after the response. Reset: config
// returns to 3/30/120; the store is swept to 0xFF, while no word is accepted.
module modbus_rtu_slave_register_engine #(
    parameter int STORE_BYTES   = mrse_pkg::STORE_BYTES_DEF,
    parameter int REQUEST_BYTES = mrse_pkg::REQUEST_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    output logic       tx_valid,
    input  logic       tx_stall,
    output logic [7:0] tx_byte,
    output logic       tx_last
);
    import mrse_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam int RW = $clog2(REQUEST_BYTES);
    localparam int LW = $clog2(REQUEST_BYTES + 1);

    cfg_t          cfg_reg;
    hdr_t          hdr;
    logic          ready;
    logic          rx_fire;
    logic [LW-1:0] frame_len;
    logic          rb_rd_en;
    logic [RW-1:0] rb_rd_addr;
    logic [7:0]    rb_rd_data;
    logic          clear_busy;
    logic          st_rd_en;
    logic [AW-1:0] st_addr;
    logic [7:0]    st_rd_data;
    logic          st_wr_en;
    logic [7:0]    st_wr_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address <= 8'd3;
            cfg_reg.read_limit    <= 5'd30;
            cfg_reg.write_limit   <= 7'd120;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLAVE_ADDRESS: cfg_reg.slave_address <= cfg_wdata;
                CFG_READ_LIMIT:    cfg_reg.read_limit    <= cfg_wdata[4:0];
                CFG_WRITE_LIMIT:   cfg_reg.write_limit   <= cfg_wdata[6:0];
                default:           ;
            endcase
        end
    end

    assign rx_stall = !ready;
    assign rx_fire  = rx_valid && ready;

    mrse_req_buf #(
        .REQUEST_BYTES(REQUEST_BYTES)
    ) u_req_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_fire   (rx_fire),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .rd_addr   (rb_rd_addr),
        .rd_en     (rb_rd_en),
        .rd_data   (rb_rd_data),
        .hdr       (hdr),
        .frame_len (frame_len)
    );

    mrse_store #(
        .STORE_BYTES(STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (st_rd_en),
        .rd_addr (st_addr),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (st_addr),
        .wr_data (st_wr_data),
        .busy    (clear_busy)
    );

    mrse_ctrl #(
        .STORE_BYTES   (STORE_BYTES),
        .REQUEST_BYTES (REQUEST_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .rx_fire    (rx_fire),
        .frame_end  (frame_end),
        .ready      (ready),
        .hdr        (hdr),
        .frame_len  (frame_len),
        .rb_rd_en   (rb_rd_en),
        .rb_rd_addr (rb_rd_addr),
        .rb_rd_data (rb_rd_data),
        .clear_busy (clear_busy),
        .st_rd_en   (st_rd_en),
        .st_addr    (st_addr),
        .st_rd_data (st_rd_data),
        .st_wr_en   (st_wr_en),
        .st_wr_data (st_wr_data),
        .tx_valid   (tx_valid),
        .tx_stall   (tx_stall),
        .tx_byte    (tx_byte),
        .tx_last    (tx_last)
    );

endmodule

// ===== sv/mrse_req_buf.sv =====
`timescale 1ns / 1ps

module mrse_req_buf #(
    parameter int REQUEST_BYTES = mrse_pkg::REQUEST_BYTES_DEF,
    localparam int RW = $clog2(REQUEST_BYTES),
    localparam int LW = $clog2(REQUEST_BYTES + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_fire,
    input  logic [7:0]          rx_byte,
    input  logic                frame_end,
    input  logic [RW-1:0]       rd_addr,
    input  logic                rd_en,
    output logic [7:0]          rd_data,
    output mrse_pkg::hdr_t      hdr,
    output logic [LW-1:0]       frame_len
);
    import mrse_pkg::*;

    logic [7:0]    mem [REQUEST_BYTES];
    logic [7:0]    rd_data_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [LW-1:0] frame_len_reg;
    hdr_t          hdr_reg;
    logic          room;

    assign room     = len_reg < LW'(REQUEST_BYTES);
    assign len_next = room ? LW'(len_reg + 1'b1) : len_reg;

    // Store the incoming word and serve reads
    always_ff @(posedge clk)
    begin
        if (rx_fire && room)
            mem[len_reg[RW-1:0]] <= rx_byte;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Track frame length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            frame_len_reg <= '0;
        end
        else if (rx_fire)
        begin
            if (frame_end)
            begin
                len_reg       <= '0;
                frame_len_reg <= len_next;
            end
            else
                len_reg <= len_next;
        end
    end

    // Capture header fields, clear them on the first word of a frame
    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            case (len_reg)
                LW'(0):
                    hdr_reg <= '0;
                LW'(1):
                    hdr_reg.func <= rx_byte;
                LW'(2):
                    hdr_reg.addr[15:8] <= rx_byte;
                LW'(3):
                    hdr_reg.addr[7:0] <= rx_byte;
                LW'(5):
                    hdr_reg.cnt <= rx_byte;
                LW'(6):
                    hdr_reg.nbytes <= rx_byte;
                default:
                    ;
            endcase
        end
    end

    assign rd_data   = rd_data_reg;
    assign hdr       = hdr_reg;
    assign frame_len = frame_len_reg;

endmodule

// ===== sv/mrse_store.sv =====
`timescale 1ns / 1ps

module mrse_store #(
    parameter int STORE_BYTES = mrse_pkg::STORE_BYTES_DEF,
    localparam int AW = $clog2(STORE_BYTES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    output logic          busy
);
    import mrse_pkg::*;

    logic [7:0]    mem [STORE_BYTES];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] clr_ptr_reg;
    logic          busy_reg;

    // Sweep the store with 0xFF after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (clr_ptr_reg == AW'(STORE_BYTES - 1))
                busy_reg <= 1'b0;
            clr_ptr_reg <= AW'(clr_ptr_reg + 1'b1);
        end
    end

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_ptr_reg] <= 8'hFF;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ===== sv/mrse_ctrl.sv =====
`timescale 1ns / 1ps

module mrse_ctrl #(
    parameter int STORE_BYTES   = mrse_pkg::STORE_BYTES_DEF,
    parameter int REQUEST_BYTES = mrse_pkg::REQUEST_BYTES_DEF,
    localparam int AW = $clog2(STORE_BYTES),
    localparam int RW = $clog2(REQUEST_BYTES),
    localparam int LW = $clog2(REQUEST_BYTES + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mrse_pkg::cfg_t cfg,
    input  logic           rx_fire,
    input  logic           frame_end,
    output logic           ready,
    input  mrse_pkg::hdr_t hdr,
    input  logic [LW-1:0]  frame_len,
    output logic           rb_rd_en,
    output logic [RW-1:0]  rb_rd_addr,
    input  logic [7:0]     rb_rd_data,
    input  logic           clear_busy,
    output logic           st_rd_en,
    output logic [AW-1:0]  st_addr,
    input  logic [7:0]     st_rd_data,
    output logic           st_wr_en,
    output logic [7:0]     st_wr_data,
    output logic           tx_valid,
    input  logic           tx_stall,
    output logic [7:0]     tx_byte,
    output logic           tx_last
);
    import mrse_pkg::*;

    // Rounded-up reciprocal of the store size, scaled by 2^32
    localparam logic [32:0] MOD_RECIP =
        33'(((64'd1 << 32) + 64'(STORE_BYTES) - 64'd1) / 64'(STORE_BYTES));

    state_t        state_reg, state_next;
    rsp_kind_t     kind_reg, kind_next;
    logic [7:0]    code_reg, code_next;
    logic [15:0]   crc_reg, crc_next;
    logic [2:0]    hidx_reg, hidx_next;
    logic [7:0]    i_reg, i_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [15:0]   rem_reg, rem_next;
    logic [3:0]    mcnt_reg, mcnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;

    logic          slot_free;
    logic          emit;
    logic [7:0]    emit_byte;
    logic          emit_last;
    logic [7:0]    rd_bytes;
    logic [7:0]    lim;
    logic [7:0]    hdr_byte;
    logic [2:0]    hdr_len;
    logic [48:0]   prod_q;
    logic [32:0]   prod_r;
    logic [15:0]   rem_step;
    logic [9:0]    wr_pos;
    logic          wr_more;
    logic [AW-1:0] ptr_inc;

    assign slot_free = !out_valid_reg || !tx_stall;
    assign rd_bytes  = {hdr.cnt[6:0], 1'b0};
    assign ready     = (state_reg == ST_IDLE) && !clear_busy;
    assign ptr_inc   = (ptr_reg == AW'(STORE_BYTES - 1)) ? '0 : AW'(ptr_reg + 1'b1);
    assign wr_pos    = 10'(i_reg) + 10'd7;
    assign wr_more   = (i_reg < hdr.nbytes) && (wr_pos < 10'(frame_len));

    // Effective read limit
    always_comb
    begin
        lim = {3'd0, cfg.read_limit};
        if (lim > MAX_READ_REGS)
            lim = MAX_READ_REGS;
        if (lim > READ_CAP)
            lim = READ_CAP;
    end

    // Start address modulo store size: quotient by reciprocal, then remainder
    always_comb
    begin
        prod_q   = 49'(hdr.addr) * 49'(MOD_RECIP);
        prod_r   = 33'(rem_reg) * 33'(STORE_BYTES);
        rem_step = hdr.addr - prod_r[15:0];
    end

    // Header word for the current response
    always_comb
    begin
        hdr_len  = 3'd3;
        hdr_byte = cfg.slave_address;
        case (kind_reg)
            RSP_EXC:
            begin
                if (hidx_reg == 3'd1)
                    hdr_byte = code_reg;
                else if (hidx_reg == 3'd2)
                    hdr_byte = EXC_ILL_VALUE;
            end
            RSP_READ:
            begin
                if (hidx_reg == 3'd1)
                    hdr_byte = FUNC_READ;
                else if (hidx_reg == 3'd2)
                    hdr_byte = rd_bytes;
            end
            RSP_WRITE:
            begin
                hdr_len = 3'd6;
                case (hidx_reg)
                    3'd1: hdr_byte = FUNC_WRITE;
                    3'd2: hdr_byte = hdr.addr[15:8];
                    3'd3: hdr_byte = hdr.addr[7:0];
                    3'd4: hdr_byte = 8'd0;
                    3'd5: hdr_byte = hdr.cnt;
                    default: hdr_byte = cfg.slave_address;
                endcase
            end
            default:
                hdr_byte = cfg.slave_address;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        code_next  = code_reg;
        crc_next   = crc_reg;
        hidx_next  = hidx_reg;
        i_next     = i_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        mcnt_next  = mcnt_reg;
        emit       = 1'b0;
        emit_byte  = hdr_byte;
        emit_last  = 1'b0;
        rb_rd_en   = 1'b0;
        rb_rd_addr = wr_pos[RW-1:0];
        st_rd_en   = 1'b0;
        st_wr_en   = 1'b0;
        st_wr_data = rb_rd_data;
        st_addr    = ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (rx_fire && frame_end)
                begin
                    mcnt_next  = 4'd0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                mcnt_next = 4'(mcnt_reg + 1'b1);
                if (mcnt_reg == 4'd0)
                    rem_next = prod_q[47:32];
                else
                begin
                    ptr_next   = rem_step[AW-1:0];
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                crc_next   = CRC_INIT;
                hidx_next  = 3'd0;
                i_next     = 8'd0;
                state_next = ST_HDR;
                if (hdr.func == FUNC_READ)
                begin
                    if (hdr.cnt >= lim)
                    begin
                        kind_next = RSP_EXC;
                        code_next = EXC_READ;
                    end
                    else
                        kind_next = RSP_READ;
                end
                else if (hdr.func == FUNC_WRITE)
                begin
                    if (hdr.cnt > {1'b0, cfg.write_limit})
                    begin
                        kind_next = RSP_EXC;
                        code_next = EXC_WRITE;
                    end
                    else
                        kind_next = RSP_WRITE;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_HDR:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    crc_next  = crc_byte(crc_reg, hdr_byte);
                    hidx_next = 3'(hidx_reg + 1'b1);
                    if (hidx_reg == 3'(hdr_len - 1'b1))
                    begin
                        if (kind_reg == RSP_READ && rd_bytes != 8'd0)
                            state_next = ST_RD_REQ;
                        else
                            state_next = ST_CRC_LO;
                    end
                end
            end
            ST_RD_REQ:
            begin
                st_rd_en   = 1'b1;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                emit_byte = st_rd_data;
                if (slot_free)
                begin
                    emit     = 1'b1;
                    crc_next = crc_byte(crc_reg, st_rd_data);
                    i_next   = 8'(i_reg + 1'b1);
                    ptr_next = ptr_inc;
                    if (8'(i_reg + 1'b1) == rd_bytes)
                        state_next = ST_CRC_LO;
                    else
                        state_next = ST_RD_REQ;
                end
            end
            ST_CRC_LO:
            begin
                emit_byte = crc_reg[7:0];
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_CRC_HI;
                end
            end
            ST_CRC_HI:
            begin
                emit_byte = crc_reg[15:8];
                emit_last = 1'b1;
                if (slot_free)
                begin
                    emit       = 1'b1;
                    i_next     = 8'd0;
                    state_next = (kind_reg == RSP_WRITE) ? ST_WR_REQ : ST_IDLE;
                end
            end
            ST_WR_REQ:
            begin
                if (wr_more)
                begin
                    rb_rd_en   = 1'b1;
                    state_next = ST_WR_DATA;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_WR_DATA:
            begin
                st_wr_en   = 1'b1;
                i_next     = 8'(i_reg + 1'b1);
                ptr_next   = ptr_inc;
                state_next = ST_WR_REQ;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
        else if (!tx_stall)
            out_valid_next = 1'b0;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= RSP_EXC;
            crc_reg       <= CRC_INIT;
            hidx_reg      <= '0;
            i_reg         <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            crc_reg       <= crc_next;
            hidx_reg      <= hidx_next;
            i_reg         <= i_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        ptr_reg      <= ptr_next;
        rem_reg      <= rem_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign tx_valid = out_valid_reg;
    assign tx_byte  = out_byte_reg;
    assign tx_last  = out_last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> slot_free) else $error("word emitted over a pending word");
    a_crc_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && state_reg == ST_CRC_HI) |=> (tx_valid && tx_last))
        else $error("final CRC word not marked last");
    a_no_wr_clear: assert property (@(posedge clk) disable iff (!rst_n)
        st_wr_en |-> !clear_busy) else $error("store write during clearing pass");
    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD_DATA |-> i_reg < rd_bytes)
        else $error("read index beyond byte count");

endmodule

// ===== tb/modbus_rtu_slave_register_engine_checker.sv =====
`timescale 1ns / 1ps

module modbus_rtu_slave_register_engine_checker
    import mrse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       rx_valid,
    input  logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    input  logic       tx_valid,
    input  logic       tx_stall,
    input  logic [7:0] tx_byte,
    input  logic       tx_last,
    output int         fail_count,
    output int         pending,
    output int         frames_seen,
    output int         words_seen
);

    localparam int STORE_N = 1024;
    localparam int REQ_N   = 32;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tx_word_t;

    logic [7:0] frame_buf [REQ_N];
    int         frame_len;
    logic [7:0] store_mem [STORE_N];
    logic [7:0] own_addr;
    logic [4:0] rd_lim;
    logic [6:0] wr_lim;
    logic [15:0] crc_acc;
    tx_word_t   response_q[$];

    assign pending = response_q.size();

    function automatic logic [7:0] frame_at(int i);
        if (i < frame_len && i < REQ_N)
            return frame_buf[i];
        return 8'd0;
    endfunction

    // Push one response word and fold it into the CRC
    function automatic void put_word(logic [7:0] b);
        tx_word_t w;
        logic [15:0] c;
        w.data = b;
        w.last = 1'b0;
        response_q.push_back(w);
        c = crc_acc ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        crc_acc = c;
    endfunction

    function automatic void put_crc();
        tx_word_t w;
        w.data = crc_acc[7:0];
        w.last = 1'b0;
        response_q.push_back(w);
        w.data = crc_acc[15:8];
        w.last = 1'b1;
        response_q.push_back(w);
    endfunction

    // Work out the response to a completed frame and update the store
    function automatic void answer_frame();
        logic [7:0] fn;
        logic [15:0] sa;
        int cnt;
        int nb;
        int lim;
        fn = frame_at(1);
        sa = {frame_at(2), frame_at(3)};
        cnt = frame_at(5);
        nb = frame_at(6);
        crc_acc = 16'hFFFF;
        if (fn == FUNC_READ)
        begin
            lim = rd_lim;
            if (lim > 30)
                lim = 30;
            if (cnt >= lim)
            begin
                put_word(own_addr);
                put_word(EXC_READ);
                put_word(EXC_ILL_VALUE);
                put_crc();
            end
            else
            begin
                put_word(own_addr);
                put_word(FUNC_READ);
                put_word(8'(cnt * 2));
                for (int i = 0; i < cnt * 2; i++)
                    put_word(store_mem[(sa + i) % STORE_N]);
                put_crc();
            end
        end
        else if (fn == FUNC_WRITE)
        begin
            if (cnt > wr_lim)
            begin
                put_word(own_addr);
                put_word(EXC_WRITE);
                put_word(EXC_ILL_VALUE);
                put_crc();
            end
            else
            begin
                put_word(own_addr);
                put_word(FUNC_WRITE);
                put_word(frame_at(2));
                put_word(frame_at(3));
                put_word(8'd0);
                put_word(8'(cnt));
                put_crc();
                for (int i = 0; i < nb; i++)
                begin
                    if (7 + i >= frame_len || 7 + i >= REQ_N)
                        break;
                    store_mem[(sa + i) % STORE_N] = frame_buf[7 + i];
                end
            end
        end
    endfunction

    // Track configuration, requests and responses
    always @(posedge clk or negedge rst_n)
    begin
        tx_word_t exp_w;
        if (!rst_n)
        begin
            frame_len = 0;
            for (int i = 0; i < STORE_N; i++)
                store_mem[i] = 8'hFF;
            own_addr = 8'd3;
            rd_lim = 5'd30;
            wr_lim = 7'd120;
            response_q.delete();
            fail_count = 0;
            frames_seen = 0;
            words_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLAVE_ADDRESS: own_addr = cfg_wdata;
                    CFG_READ_LIMIT:    rd_lim = cfg_wdata[4:0];
                    CFG_WRITE_LIMIT:   wr_lim = cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (tx_valid && !tx_stall)
            begin
                words_seen++;
                if (response_q.size() == 0)
                begin
                    $error("unexpected tx word %02h last %0b", tx_byte, tx_last);
                    fail_count++;
                end
                else
                begin
                    exp_w = response_q.pop_front();
                    if (tx_byte !== exp_w.data)
                    begin
                        $error("tx_byte expected %02h actual %02h", exp_w.data, tx_byte);
                        fail_count++;
                    end
                    if (tx_last !== exp_w.last)
                    begin
                        $error("tx_last expected %0b actual %0b", exp_w.last, tx_last);
                        fail_count++;
                    end
                end
            end
            if (rx_valid && !rx_stall)
            begin
                if (frame_len < REQ_N)
                begin
                    frame_buf[frame_len] = rx_byte;
                    frame_len++;
                end
                if (frame_end)
                begin
                    answer_frame();
                    frame_len = 0;
                    frames_seen++;
                end
            end
        end
    end

endmodule

// ===== tb/modbus_rtu_slave_register_engine_test.sv =====
`timescale 1ns / 1ps

module modbus_rtu_slave_register_engine_test;
    import mrse_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic       rx_valid;
    logic       rx_stall;
    logic [7:0] rx_byte;
    logic       frame_end;
    logic       tx_valid;
    logic       tx_stall;
    logic [7:0] tx_byte;
    logic       tx_last;
    int         fail_count;
    int         pending;
    int         frames_seen;
    int         words_seen;
    int         cycle_count;
    int         words_sent;
    bit         hold_off_req;
    bit         no_gaps;
    logic [8:0] frame_q[$];

    modbus_rtu_slave_register_engine u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .rx_valid(rx_valid), .rx_stall(rx_stall),
        .rx_byte(rx_byte), .frame_end(frame_end), .tx_valid(tx_valid),
        .tx_stall(tx_stall), .tx_byte(tx_byte), .tx_last(tx_last)
    );

    modbus_rtu_slave_register_engine_checker u_check (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .rx_valid(rx_valid), .rx_stall(rx_stall),
        .rx_byte(rx_byte), .frame_end(frame_end), .tx_valid(tx_valid),
        .tx_stall(tx_stall), .tx_byte(tx_byte), .tx_last(tx_last),
        .fail_count(fail_count), .pending(pending), .frames_seen(frames_seen),
        .words_seen(words_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 1500000)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: random stalls per word, or a long hold-off on request
    initial
    begin
        int gap;
        tx_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                tx_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off_req = 1'b0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                tx_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            tx_stall <= 1'b0;
            @(posedge clk);
            while (!tx_valid)
                @(posedge clk);
        end
    end

    // Hand one word to the block and wait for it to be taken
    task automatic send_word(logic [7:0] b, logic e);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        frame_end <= e;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_frame();
        logic [8:0] w;
        while (frame_q.size() > 0)
        begin
            w = frame_q.pop_front();
            send_word(w[7:0], w[8]);
        end
    endtask

    // Build a request: address, function, start, count and optional write data
    task automatic build_req(logic [7:0] fn, logic [15:0] sa, logic [7:0] cnt,
                             logic [7:0] nb, int data_n);
        frame_q.delete();
        frame_q.push_back({1'b0, 8'($urandom)});
        frame_q.push_back({1'b0, fn});
        frame_q.push_back({1'b0, sa[15:8]});
        frame_q.push_back({1'b0, sa[7:0]});
        frame_q.push_back({1'b0, 8'($urandom)});
        frame_q.push_back({1'b0, cnt});
        if (fn == FUNC_WRITE)
        begin
            frame_q.push_back({1'b0, nb});
            for (int i = 0; i < data_n; i++)
                frame_q.push_back({1'b0, 8'($urandom)});
        end
        frame_q[frame_q.size() - 1][8] = 1'b1;
    endtask

    task automatic drain();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int pick;
        int cnt;
        cfg_we = 1'b0;
        cfg_index = CFG_SLAVE_ADDRESS;
        cfg_wdata = 8'd0;
        rx_valid = 1'b0;
        rx_byte = 8'd0;
        frame_end = 1'b0;
        hold_off_req = 1'b0;
        no_gaps = 1'b0;
        words_sent = 0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset defaults, reads over erased store, limits and odd frames
        build_req(FUNC_READ, 16'h0000, 8'd1, 8'd0, 0);
        send_frame();
        build_req(FUNC_WRITE, 16'h03FE, 8'd2, 8'd4, 4);
        send_frame();
        build_req(FUNC_READ, 16'hFFFE, 8'd29, 8'd0, 0);
        send_frame();
        build_req(FUNC_READ, 16'h0010, 8'd30, 8'd0, 0);
        send_frame();
        build_req(FUNC_WRITE, 16'h0000, 8'd121, 8'd2, 2);
        send_frame();
        build_req(FUNC_WRITE, 16'h0100, 8'd120, 8'd255, 40);
        send_frame();
        build_req(FUNC_READ, 16'h0100, 8'd0, 8'd0, 0);
        send_frame();
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(FUNC_READ, 1'b1);
        send_word(8'h11, 1'b0);
        send_word(8'h22, 1'b1);
        drain();

        // Walk the configuration through its extremes, then random values
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    write_cfg(CFG_SLAVE_ADDRESS, 8'd0);
                    write_cfg(CFG_READ_LIMIT, 8'd0);
                    write_cfg(CFG_WRITE_LIMIT, 8'd0);
                end
                1:
                begin
                    write_cfg(CFG_SLAVE_ADDRESS, 8'd255);
                    write_cfg(CFG_READ_LIMIT, 8'd31);
                    write_cfg(CFG_WRITE_LIMIT, 8'd127);
                end
                default:
                begin
                    write_cfg(CFG_SLAVE_ADDRESS, 8'($urandom));
                    write_cfg(CFG_READ_LIMIT, 8'($urandom_range(0, 31)));
                    write_cfg(CFG_WRITE_LIMIT, 8'($urandom_range(0, 127)));
                end
            endcase
            no_gaps = (phase == 3);
            for (int f = 0; f < 3; f++)
            begin
                if (phase == 2 && f == 1)
                    hold_off_req = 1'b1;
                pick = $urandom_range(0, 9);
                cnt = $urandom_range(0, 8);
                if (pick < 4)
                    build_req(FUNC_READ, 16'($urandom), 8'(cnt),
                              8'd0, 0);
                else if (pick < 8)
                    build_req(FUNC_WRITE, {6'($urandom), 10'($urandom)}, 8'(cnt),
                              8'(cnt * 2), $urandom_range(0, 26));
                else
                begin
                    frame_q.delete();
                    for (int i = $urandom_range(1, 40); i > 0; i--)
                        frame_q.push_back({i == 1, 8'($urandom)});
                end
                send_frame();
            end
            no_gaps = 1'b0;
            // Pause until every response has arrived
            drain();
        end

        $display("sent %0d request words in %0d frames, checked %0d response words",
                 words_sent, frames_seen, words_seen);
        $display("covered reads, writes, exceptions, short/long frames and config extremes");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mrse_pkg.sv
sv/mrse_req_buf.sv
sv/mrse_store.sv
sv/mrse_ctrl.sv
sv/modbus_rtu_slave_register_engine.sv
tb/modbus_rtu_slave_register_engine_checker.sv
tb/modbus_rtu_slave_register_engine_test.sv
